>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clock and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/usc_pkg.sv
// ----------------------------------------------------------------------------
// usc_pkg
// constants, types and month table for the seconds to calendar converter
// ----------------------------------------------------------------------------
package usc_pkg;

   typedef logic [8:0]  doy_type;
   typedef logic [3:0]  month_type;
   typedef logic [4:0]  mday_type;
   typedef logic [11:0] year_type;

   localparam logic [31:0] LIMIT_SECONDS = 32'd4102444800;
   localparam logic [31:0] DAY_SECS      = 32'd86400;
   localparam logic [15:0] CYCLE_DAYS    = 16'd1461;
   localparam logic [11:0] HOUR_SECS     = 12'd3600;
   localparam logic [11:0] MINUTE_SECS   = 12'd60;
   localparam logic [11:0] EPOCH_YEAR    = 12'd1970;

   localparam logic [10:0] YEAR1_START = 11'd365;
   localparam logic [10:0] YEAR2_START = 11'd730;
   localparam logic [10:0] YEAR3_START = 11'd1096;

   // reciprocals rounded up, exact for the operand ranges in use
   localparam int unsigned DAY_SHIFT    = 35;
   localparam int unsigned CYCLE_SHIFT  = 27;
   localparam int unsigned HOUR_SHIFT   = 29;
   localparam int unsigned MINUTE_SHIFT = 18;

   localparam logic [25:0] DAY_RECIP =
      26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
   localparam logic [16:0] CYCLE_RECIP =
      17'(((64'd1 << CYCLE_SHIFT) + 64'd1460) / 64'd1461);
   localparam logic [17:0] HOUR_RECIP =
      18'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);
   localparam logic [12:0] MINUTE_RECIP =
      13'(((64'd1 << MINUTE_SHIFT) + 64'd59) / 64'd60);

   // first day of each month within a year, counted from zero
   function automatic doy_type month_start(input logic leap, input month_type idx);
      doy_type base;
      base = '0;
      unique case (idx)
         4'd0:  base = 9'd0;
         4'd1:  base = 9'd31;
         4'd2:  base = 9'd59;
         4'd3:  base = 9'd90;
         4'd4:  base = 9'd120;
         4'd5:  base = 9'd151;
         4'd6:  base = 9'd181;
         4'd7:  base = 9'd212;
         4'd8:  base = 9'd243;
         4'd9:  base = 9'd273;
         4'd10: base = 9'd304;
         4'd11: base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && (idx >= 4'd2)) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

>>> design/unix_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar
// converts seconds since 1970-01-01 00:00:00 to civil date and time of day
// ----------------------------------------------------------------------------
// One transaction can enter on every clock and its result is presented on
// rsp_valid out of the last of six register stages; a stall on the result
// side holds the pipeline in place and bubbles are squeezed out. Each stage
// holds at most one constant-reciprocal multiply (days, four-year cycles,
// hours, minutes) beside remainder subtract and compare steps. Timestamps
// from 2100-01-01 00:00:00 on raise rsp_out_of_range with all other result
// fields at zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module unix_seconds_to_calendar
   import usc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic        rsp_out_of_range
);

   // stage valids and enables
   logic [5:0] vld_ff;
   logic [5:0] en;

   assign en[5] = !vld_ff[5] || rsp_ready;
   assign en[4] = !vld_ff[4] || en[5];
   assign en[3] = !vld_ff[3] || en[4];
   assign en[2] = !vld_ff[2] || en[3];
   assign en[1] = !vld_ff[1] || en[2];
   assign en[0] = !vld_ff[0] || en[1];

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < 6; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // stage 1: day count
   logic [50:0] day_prod;
   logic [15:0] days1_ff;
   logic [16:0] sec_lo1_ff;
   logic        oor1_ff;

   assign day_prod = 51'(req_seconds[31:7]) * 51'(DAY_RECIP);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         days1_ff   <= day_prod[50:35];
         sec_lo1_ff <= req_seconds[16:0];
         oor1_ff    <= (req_seconds >= LIMIT_SECONDS);
      end
   end

   // stage 2: time of day and four-year cycle
   logic [32:0] cyc_prod;
   logic [16:0] tod2_in;
   logic [16:0] tod2_ff;
   logic [5:0]  cycles2_ff;
   logic [15:0] days2_ff;
   logic        oor2_ff;

   assign cyc_prod = 33'(days1_ff) * 33'(CYCLE_RECIP);
   assign tod2_in  = sec_lo1_ff - 17'(32'(days1_ff) * DAY_SECS);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         tod2_ff    <= tod2_in;
         cycles2_ff <= cyc_prod[32:27];
         days2_ff   <= days1_ff;
         oor2_ff    <= oor1_ff;
      end
   end

   // stage 3: day of cycle and hour
   logic [34:0] hour_prod;
   logic [10:0] doc3_in;
   logic [10:0] doc3_ff;
   logic [4:0]  hour3_ff;
   logic [16:0] tod3_ff;
   logic [5:0]  cycles3_ff;
   logic        oor3_ff;

   assign hour_prod = 35'(tod2_ff) * 35'(HOUR_RECIP);
   assign doc3_in   = 11'(days2_ff - 16'(16'(cycles2_ff) * CYCLE_DAYS));

   always_ff @(posedge clock) begin
      if (en[2]) begin
         doc3_ff    <= doc3_in;
         hour3_ff   <= hour_prod[33:29];
         tod3_ff    <= tod2_ff;
         cycles3_ff <= cycles2_ff;
         oor3_ff    <= oor2_ff;
      end
   end

   // stage 4: year within cycle, seconds within hour
   logic [1:0]  yoff;
   logic [10:0] doy_full;
   logic [11:0] rem4_in;
   doy_type     doy4_ff;
   logic        leap4_ff;
   year_type    year4_ff;
   logic [11:0] rem4_ff;
   logic [4:0]  hour4_ff;
   logic        oor4_ff;

   always_comb begin
      if (doc3_ff >= YEAR3_START) begin
         yoff     = 2'd3;
         doy_full = doc3_ff - YEAR3_START;
      end else if (doc3_ff >= YEAR2_START) begin
         yoff     = 2'd2;
         doy_full = doc3_ff - YEAR2_START;
      end else if (doc3_ff >= YEAR1_START) begin
         yoff     = 2'd1;
         doy_full = doc3_ff - YEAR1_START;
      end else begin
         yoff     = 2'd0;
         doy_full = doc3_ff;
      end
   end

   assign rem4_in = 12'(tod3_ff - 17'(17'(hour3_ff) * 17'(HOUR_SECS)));

   always_ff @(posedge clock) begin
      if (en[3]) begin
         doy4_ff  <= doy_full[8:0];
         leap4_ff <= (yoff == 2'd2);
         year4_ff <= EPOCH_YEAR + {4'd0, cycles3_ff, 2'd0} + 12'(yoff);
         rem4_ff  <= rem4_in;
         hour4_ff <= hour3_ff;
         oor4_ff  <= oor3_ff;
      end
   end

   // stage 5: month, day of month and minute
   logic [24:0] min_prod;
   month_type   month5_in;
   mday_type    mday5_in;
   month_type   month5_ff;
   mday_type    mday5_ff;
   logic [5:0]  minute5_ff;
   logic [11:0] rem5_ff;
   logic [4:0]  hour5_ff;
   year_type    year5_ff;
   logic        oor5_ff;

   assign min_prod = 25'(rem4_ff) * 25'(MINUTE_RECIP);

   usc_month_find u_month_find (
      .doy   (doy4_ff),
      .leap  (leap4_ff),
      .month (month5_in),
      .mday  (mday5_in)
   );

   always_ff @(posedge clock) begin
      if (en[4]) begin
         month5_ff  <= month5_in;
         mday5_ff   <= mday5_in;
         minute5_ff <= min_prod[23:18];
         rem5_ff    <= rem4_ff;
         hour5_ff   <= hour4_ff;
         year5_ff   <= year4_ff;
         oor5_ff    <= oor4_ff;
      end
   end

   // stage 6: second and result register
   logic [5:0]  second6_in;
   year_type    rsp_year_ff;
   month_type   rsp_month_ff;
   mday_type    rsp_mday_ff;
   logic [4:0]  rsp_hour_ff;
   logic [5:0]  rsp_minute_ff;
   logic [5:0]  rsp_second_ff;
   logic        rsp_oor_ff;

   assign second6_in = 6'(rem5_ff - 12'(12'(minute5_ff) * MINUTE_SECS));

   always_ff @(posedge clock) begin
      if (en[5]) begin
         rsp_oor_ff <= oor5_ff;
         if (oor5_ff) begin
            rsp_year_ff   <= '0;
            rsp_month_ff  <= '0;
            rsp_mday_ff   <= '0;
            rsp_hour_ff   <= '0;
            rsp_minute_ff <= '0;
            rsp_second_ff <= '0;
         end else begin
            rsp_year_ff   <= year5_ff;
            rsp_month_ff  <= month5_ff;
            rsp_mday_ff   <= mday5_ff;
            rsp_hour_ff   <= hour5_ff;
            rsp_minute_ff <= minute5_ff;
            rsp_second_ff <= second6_in;
         end
      end
   end

   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day_of_month = rsp_mday_ff;
   assign rsp_hour         = rsp_hour_ff;
   assign rsp_minute       = rsp_minute_ff;
   assign rsp_second       = rsp_second_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // checks
   `ASSERT_NEXT(a_accept_fills_stage1, req_valid && req_ready, vld_ff[0])
   `ASSERT_IMP(a_month_range, rsp_valid && !rsp_out_of_range,
      rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day_of_month >= 5'd1)
   `ASSERT_IMP(a_time_range, rsp_valid && !rsp_out_of_range,
      rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59)
   `ASSERT_IMP(a_oor_zeroed, rsp_valid && rsp_out_of_range,
      rsp_year == 12'd0 && rsp_month == 4'd0)

endmodule

>>> design/usc_month_find.sv
// ----------------------------------------------------------------------------
// usc_month_find
// places a day of the year into its month and day of month
// ----------------------------------------------------------------------------
module usc_month_find
   import usc_pkg::*;
(
   input  doy_type   doy,
   input  logic      leap,
   output month_type month,
   output mday_type  mday
);

   month_type idx;
   doy_type   offset;

   // month starts rise monotonically, so the last one passed wins
   always_comb begin
      idx = '0;
      for (int i = 1; i < 12; i++) begin
         if (doy >= month_start(leap, 4'(i))) begin
            idx = 4'(i);
         end
      end
   end

   assign offset = doy - month_start(leap, idx);
   assign month  = idx + 4'd1;
   assign mday   = 5'(offset) + 5'd1;

endmodule

>>> sim/tb_unix_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// tb_unix_seconds_to_calendar
// drives directed edge timestamps and random bursts of seconds counts into the
// converter, predicts each calendar date in the bench and checks every result
// field in order, under random sender gaps, receiver stalls and a long hold-off
// ----------------------------------------------------------------------------
module tb_unix_seconds_to_calendar
   import usc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS      = 1585;
   localparam int unsigned FLOOD_ITEMS       = 40;
   localparam int unsigned LONG_STALL_CYCLES = 120;
   localparam int unsigned DRAIN_CYCLES      = 20;
   localparam int unsigned LAST_DAY          = 47481;

   localparam int unsigned MONTH_DAYS [2][12] = '{
      '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31},
      '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31}
   };

   localparam logic [31:0] EDGE_SECONDS [25] = '{
      32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      58 * 86400 + 86399, 59 * 86400,
      365 * 86400 - 1, 365 * 86400,
      730 * 86400 - 1, 730 * 86400,
      789 * 86400, 790 * 86400 - 1, 790 * 86400,
      1096 * 86400 - 1, 1096 * 86400,
      1155 * 86400 - 1, 1461 * 86400,
      LIMIT_SECONDS - 32'd1, LIMIT_SECONDS,
      32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555
   };

   typedef struct packed {
      year_type    year;
      month_type   month;
      mday_type    day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        out_of_range;
   } calendar_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_seconds;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic        rsp_out_of_range;

   bit long_stall_req = 1'b0;

   function automatic calendar_type predict_calendar(input logic [31:0] secs);
      calendar_type date;
      int unsigned  days;
      int unsigned  tod;
      int unsigned  quad;
      int unsigned  doc;
      int unsigned  yoff;
      int unsigned  m;
      int unsigned  leap;
      date = '0;
      if (secs >= LIMIT_SECONDS) begin
         date.out_of_range = 1'b1;
         return date;
      end
      days = secs / DAY_SECS;
      tod  = secs % DAY_SECS;
      quad = days / CYCLE_DAYS;
      doc  = days % CYCLE_DAYS;
      if (doc >= YEAR3_START) begin
         yoff = 3;
         doc  = doc - YEAR3_START;
      end else if (doc >= YEAR2_START) begin
         yoff = 2;
         doc  = doc - YEAR2_START;
      end else if (doc >= YEAR1_START) begin
         yoff = 1;
         doc  = doc - YEAR1_START;
      end else begin
         yoff = 0;
      end
      // third year of each four-year cycle is the leap one
      leap = (yoff == 2) ? 1 : 0;
      m = 0;
      while (m < 11 && doc >= MONTH_DAYS[leap][m]) begin
         doc = doc - MONTH_DAYS[leap][m];
         m++;
      end
      date.year         = year_type'(EPOCH_YEAR + quad * 4 + yoff);
      date.month        = month_type'(m + 1);
      date.day_of_month = mday_type'(doc + 1);
      date.hour         = 5'(tod / HOUR_SECS);
      date.minute       = 6'((tod % HOUR_SECS) / MINUTE_SECS);
      date.second       = 6'(tod % MINUTE_SECS);
      return date;
   endfunction

   class date_checker;
      calendar_type expected_dates[$];
      int unsigned  mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void note_seconds(input logic [31:0] secs);
         expected_dates.push_back(predict_calendar(secs));
      endfunction

      function int unsigned pending();
         return expected_dates.size();
      endfunction

      function void check_date(input calendar_type got);
         calendar_type want;
         if (expected_dates.size() == 0) begin
            $error("result transaction with no expected date pending");
            mismatches++;
            return;
         end
         want = expected_dates.pop_front();
         if (got.year !== want.year) begin
            $error("year expected %0d actual %0d", want.year, got.year);
            mismatches++;
         end
         if (got.month !== want.month) begin
            $error("month expected %0d actual %0d", want.month, got.month);
            mismatches++;
         end
         if (got.day_of_month !== want.day_of_month) begin
            $error("day_of_month expected %0d actual %0d", want.day_of_month,
                   got.day_of_month);
            mismatches++;
         end
         if (got.hour !== want.hour) begin
            $error("hour expected %0d actual %0d", want.hour, got.hour);
            mismatches++;
         end
         if (got.minute !== want.minute) begin
            $error("minute expected %0d actual %0d", want.minute, got.minute);
            mismatches++;
         end
         if (got.second !== want.second) begin
            $error("second expected %0d actual %0d", want.second, got.second);
            mismatches++;
         end
         if (got.out_of_range !== want.out_of_range) begin
            $error("out_of_range expected %0d actual %0d", want.out_of_range,
                   got.out_of_range);
            mismatches++;
         end
      endfunction
   endclass

   date_checker dates = new();

   unix_seconds_to_calendar i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_seconds      (req_seconds),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_out_of_range (rsp_out_of_range)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            dates.note_seconds(req_seconds);
         end
         if (rsp_valid && rsp_ready) begin
            dates.check_date('{rsp_year, rsp_month, rsp_day_of_month, rsp_hour,
                               rsp_minute, rsp_second, rsp_out_of_range});
         end
      end
   end

   // receiver: random stall modes, plus one long hold-off on request
   initial begin
      int unsigned mode;
      int unsigned mode_left;
      bit          long_stall_done;
      mode            = 0;
      mode_left       = 0;
      long_stall_done = 1'b0;
      rsp_ready       = 1'b0;
      forever begin
         @(posedge clock);
         if (long_stall_req && !long_stall_done) begin
            long_stall_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= mode_left[2];
         endcase
      end
   end

   task automatic drive_request(input logic [31:0] secs);
      req_valid   <= 1'b1;
      req_seconds <= secs;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_cycles(input int unsigned count);
      req_valid <= 1'b0;
      repeat (count) @(posedge clock);
   endtask

   task automatic wait_drained();
      idle_cycles(1);
      while (dates.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] random_seconds();
      int unsigned kind;
      int unsigned days;
      int unsigned tod;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1: return $urandom;
         2, 3, 4: return $urandom_range(0, LIMIT_SECONDS - 32'd1);
         9: return LIMIT_SECONDS - 32'd4096 + $urandom_range(0, 8191);
         default: begin
            days = $urandom_range(0, LAST_DAY);
            case ($urandom_range(0, 2))
               0: tod = 0;
               1: tod = DAY_SECS - 1;
               default: tod = $urandom_range(0, DAY_SECS - 1);
            endcase
            return days * DAY_SECS + tod;
         end
      endcase
   endfunction

   initial begin
      int unsigned sent;
      int unsigned burst;
      bit          drained_mid;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_seconds = '0;
      sent        = 0;
      drained_mid = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (EDGE_SECONDS[i]) begin
         drive_request(EDGE_SECONDS[i]);
         if ($urandom_range(0, 2) == 0) begin
            idle_cycles($urandom_range(1, 4));
         end
      end
      wait_drained();

      // flood while the receiver holds off so the pipeline backs up
      long_stall_req = 1'b1;
      repeat (FLOOD_ITEMS) drive_request(random_seconds());

      while (sent < RANDOM_ITEMS) begin
         burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                             : $urandom_range(1, 16);
         for (int unsigned k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            drive_request(random_seconds());
            sent++;
         end
         if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
            drained_mid = 1'b1;
            wait_drained();
         end else if ($urandom_range(0, 3) != 0) begin
            idle_cycles($urandom_range(1, 8));
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (dates.mismatches == 0 && dates.pending() == 0) begin
         $display("[unix_seconds_to_calendar] OK");
      end else begin
         $display("[unix_seconds_to_calendar] ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[unix_seconds_to_calendar] ERROR");
      $finish;
   end

endmodule
